FILE: hw/rtl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
package tksd_pkg;

  // Parse phase of the escape sequence recognizer
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_BRK   = 2'd2,
    PH_DIGIT = 2'd3
  } phase_t;

  // Key event codes
  typedef enum logic [3:0] {
    KIND_NORMAL    = 4'd0,
    KIND_ENTER     = 4'd1,
    KIND_BACKSPACE = 4'd2,
    KIND_UP        = 4'd3,
    KIND_DOWN      = 4'd4,
    KIND_LEFT      = 4'd5,
    KIND_RIGHT     = 4'd6,
    KIND_HOME      = 4'd7,
    KIND_END       = 4'd8,
    KIND_DELETE    = 4'd9
  } key_kind_t;

  // Pending digit codes seen after ESC [
  localparam logic [1:0] DIG_NONE = 2'd0;
  localparam logic [1:0] DIG_HOME = 2'd1;
  localparam logic [1:0] DIG_DEL  = 2'd2;
  localparam logic [1:0] DIG_END  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Input request
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_input;
  } in_req_t;

  // Result request
  typedef struct packed {
    key_kind_t  key_kind;
    logic [7:0] key_char;
    logic       char_is_end;
  } out_req_t;

  // Decoder step result
  typedef struct packed {
    logic       emit;
    out_req_t   res;
    phase_t     phase_nxt;
    logic [1:0] digit_nxt;
  } dec_res_t;

endpackage

FILE: hw/rtl/tksd_decode.sv
// Combinational decode of one input byte against the current parse phase.
module tksd_decode (
  input  tksd_pkg::phase_t   phase,
  input  logic [1:0]         digit,
  input  tksd_pkg::in_req_t  req,
  output tksd_pkg::dec_res_t dec
);

  logic               eoi;
  logic [7:0]         b;
  tksd_pkg::phase_t   phase_nxt;
  logic [1:0]         digit_nxt;
  logic               emit;
  tksd_pkg::out_req_t res;

  assign eoi = req.end_of_input;
  assign b   = req.rx_byte;

  // Next phase and pending digit
  always_comb begin
    phase_nxt = tksd_pkg::PH_IDLE;
    digit_nxt = digit;
    unique case (phase)
      tksd_pkg::PH_IDLE: begin
        if (!eoi && b == tksd_pkg::CH_ESC) phase_nxt = tksd_pkg::PH_ESC;
      end
      tksd_pkg::PH_ESC: begin
        if (!eoi && b == tksd_pkg::CH_LBRK) phase_nxt = tksd_pkg::PH_BRK;
      end
      tksd_pkg::PH_BRK: begin
        if (!eoi) begin
          unique case (b)
            tksd_pkg::CH_ONE: begin
              digit_nxt = tksd_pkg::DIG_HOME;
              phase_nxt = tksd_pkg::PH_DIGIT;
            end
            tksd_pkg::CH_THREE: begin
              digit_nxt = tksd_pkg::DIG_DEL;
              phase_nxt = tksd_pkg::PH_DIGIT;
            end
            tksd_pkg::CH_FOUR: begin
              digit_nxt = tksd_pkg::DIG_END;
              phase_nxt = tksd_pkg::PH_DIGIT;
            end
            default: phase_nxt = tksd_pkg::PH_IDLE;
          endcase
        end
      end
      tksd_pkg::PH_DIGIT: phase_nxt = tksd_pkg::PH_IDLE;
      default: phase_nxt = tksd_pkg::PH_IDLE;
    endcase
  end

  // Result of this byte
  always_comb begin
    emit            = 1'b1;
    res.key_kind    = tksd_pkg::KIND_NORMAL;
    res.key_char    = 8'd0;
    res.char_is_end = 1'b0;
    unique case (phase)
      tksd_pkg::PH_IDLE: begin
        if (eoi) begin
          res.key_kind = tksd_pkg::KIND_ENTER;
        end else begin
          unique case (b) inside
            tksd_pkg::CH_CR, tksd_pkg::CH_LF: res.key_kind = tksd_pkg::KIND_ENTER;
            tksd_pkg::CH_BS, tksd_pkg::CH_DEL: res.key_kind = tksd_pkg::KIND_BACKSPACE;
            tksd_pkg::CH_ESC: emit = 1'b0;
            default: res.key_char = b;
          endcase
        end
      end
      tksd_pkg::PH_ESC: begin
        if (eoi) begin
          res.char_is_end = 1'b1;
        end else if (b == tksd_pkg::CH_LBRK) begin
          emit = 1'b0;
        end else begin
          res.key_char = b;
        end
      end
      tksd_pkg::PH_BRK: begin
        if (eoi) begin
          res.char_is_end = 1'b1;
        end else begin
          unique case (b) inside
            tksd_pkg::CH_A: res.key_kind = tksd_pkg::KIND_UP;
            tksd_pkg::CH_B: res.key_kind = tksd_pkg::KIND_DOWN;
            tksd_pkg::CH_D: res.key_kind = tksd_pkg::KIND_LEFT;
            tksd_pkg::CH_C: res.key_kind = tksd_pkg::KIND_RIGHT;
            tksd_pkg::CH_H: res.key_kind = tksd_pkg::KIND_HOME;
            tksd_pkg::CH_F: res.key_kind = tksd_pkg::KIND_END;
            tksd_pkg::CH_ONE, tksd_pkg::CH_THREE, tksd_pkg::CH_FOUR: emit = 1'b0;
            default: res.key_char = b;
          endcase
        end
      end
      tksd_pkg::PH_DIGIT: begin
        if (eoi) begin
          res.char_is_end = 1'b1;
        end else if (b == tksd_pkg::CH_TILDE) begin
          unique case (digit)
            tksd_pkg::DIG_DEL: res.key_kind = tksd_pkg::KIND_DELETE;
            tksd_pkg::DIG_END: res.key_kind = tksd_pkg::KIND_END;
            // no digit recorded: treat as home
            tksd_pkg::DIG_NONE, tksd_pkg::DIG_HOME: res.key_kind = tksd_pkg::KIND_HOME;
            default: res.key_kind = tksd_pkg::KIND_HOME;
          endcase
        end else begin
          res.key_char = b;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  // Pack the step result
  assign dec = {emit, res, phase_nxt, digit_nxt};

endmodule

FILE: hw/rtl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder with its output buffering.
//
// Usage: feed one received byte (or an end-of-input mark) per request on the
// in_ channel; key events leave on the out_ channel, zero or one per request.
// ESC, ESC [ and ESC [ digit produce no event; the completing or breaking byte
// does. A request is taken when in_valid is high and in_stall is low, and a
// result when out_valid is high and out_stall is low.
// An accepted request's result is registered in the output register, or in the skid entry if stalled.
// Throughput: one request per cycle while in_stall is low; the phase register
// update is the only loop, one decode step deep.
// Stall: the output register is backed by one skid entry, so a request is
// still taken in the cycle the receiver first stalls; in_stall rises only
// while the skid entry holds a result and drops once the output drains.
// Reset: rst_n low clears the parse phase to idle, the pending digit to zero and both buffer
// entries to empty; the user must ensure no request is taken during reset; the block does not enforce it.
module terminal_key_sequence_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tksd_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tksd_pkg::out_req_t out_data
);

  tksd_pkg::phase_t   phase_r;
  logic [1:0]         digit_r;
  tksd_pkg::dec_res_t dec;
  logic               in_acc;
  logic               out_free;
  logic               new_res;
  logic               out_valid_r;
  tksd_pkg::out_req_t out_data_r;
  logic               skid_valid_r;
  tksd_pkg::out_req_t skid_data_r;

  tksd_decode u_decode (
    .phase (phase_r),
    .digit (digit_r),
    .req   (in_data),
    .dec   (dec)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign new_res  = in_acc && dec.emit;

  // Advance the parse state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tksd_pkg::PH_IDLE;
      digit_r <= tksd_pkg::DIG_NONE;
    end else if (in_acc) begin
      phase_r <= dec.phase_nxt;
      digit_r <= dec.digit_nxt;
    end
  end

  // Output register and skid entry control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (new_res) begin
      if (out_free) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) out_data_r <= skid_data_r;
    end else if (new_res) begin
      if (out_free) out_data_r <= dec.res;
      else skid_data_r <= dec.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/tksd_check.sv
// Port-level checker for the terminal key sequence decoder, bound to the top.
module tksd_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tksd_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tksd_pkg::out_req_t out_data
);

  // Reset empties both buffer entries
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Non-normal keys carry no character
  a_kind_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_kind != tksd_pkg::KIND_NORMAL
      |-> out_data.key_char == 8'd0 && !out_data.char_is_end)
    else $error("special key carries a character");

  // End-of-input breakage yields an empty normal key
  a_end_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_is_end
      |-> out_data.key_kind == tksd_pkg::KIND_NORMAL && out_data.key_char == 8'd0)
    else $error("end mark with bad payload");

  // Input stall only rises while the receiver is stalling a result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

endmodule

bind terminal_key_sequence_decoder tksd_check u_tksd_check (.*);
